[hw/rtl/mtc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types, sizes and helpers of the multi-tau correlator.
// ----------------------------------------------------------------------------
package mtc_pkg;

    localparam int LEVELS    = 32;
    localparam int POINTS    = 16;   // power of two
    localparam int AVERAGING = 2;    // power of two

    localparam int CELLS     = LEVELS * POINTS;
    localparam int FIRST_LAG = POINTS / AVERAGING;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int PT_W      = $clog2(POINTS);
    localparam int CELL_W    = $clog2(CELLS);
    localparam int FILL_W    = $clog2(POINTS + 1);
    localparam int AVG_SH    = $clog2(AVERAGING);
    localparam int BFILL_W   = $clog2(AVERAGING + 1);

    localparam int SMP_W     = 24;
    localparam int BSUM_W    = 27;
    localparam int SUM_W     = 64;
    localparam int CNT_W     = 48;
    localparam int TIME_W    = 36;
    localparam int PROD_W    = 2 * SMP_W;
    localparam int WIDE_T_W  = ((4 + (LEVELS - 1) * AVG_SH) > TIME_W ?
                                (4 + (LEVELS - 1) * AVG_SH) : TIME_W) + 1;

    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [CNT_W-1:0]        CNT_MAX  = '1;
    localparam logic [TIME_W-1:0]       TIME_MAX = '1;
    localparam logic signed [SUM_W-1:0] SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [15:0] sample;
        logic [4:0]         level;
        logic [3:0]         lag;
        logic               subtract_mean;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]       lag_time;
        logic signed [SUM_W-1:0] mean_product;
        logic [CNT_W-1:0]        pair_total;
        logic                    valid_res;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_SKIP,
        KIND_READ
    } kind_t;

    typedef struct packed {
        kind_t    kind;
        in_item_t item;
    } cmd_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        cnt;
    } acc_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_LVL,
        ST_ADD_LAG,
        ST_ADD_DRAIN,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_DIV_Q,
        ST_DIV_M,
        ST_MSQ,
        ST_RD_FIN
    } state_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W-1:0] s;
        s = a + b;
        if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1])
            return a[SUM_W-1] ? SUM_MIN : SUM_MAX;
        return s;
    endfunction

    function automatic logic [SUM_W-1:0] mag64(input logic signed [SUM_W-1:0] a);
        return a[SUM_W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic [CELL_W-1:0] cell_addr(
        input logic [LVL_W-1:0] k,
        input logic [PT_W-1:0]  j
    );
        return CELL_W'(int'(k) * POINTS + int'(j));
    endfunction

endpackage

[hw/rtl/mtc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_front
// Accepts input transactions, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
module mtc_front
    import mtc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_item_t item,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_ready
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    cmd_t       new_cmd;

    always_comb
    begin
        new_cmd.item = item;
        if (item.op == OP_READ)
            new_cmd.kind = KIND_READ;
        else if (int'(item.level) < LEVELS)
            new_cmd.kind = KIND_ADD;
        else
            new_cmd.kind = KIND_SKIP;
    end

    assign item_ready = (cnt_reg != 2'd2);
    assign cmd_valid  = (cnt_reg != 2'd0);
    assign cmd        = slot_reg[rd_ptr_reg];
    assign push       = item_valid && item_ready;
    assign pop        = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= new_cmd;
    end

endmodule

[hw/rtl/mtc_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtc_divider
    import mtc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_STEPS);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[hw/rtl/mtc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_back
// Executes queued transactions: ring insert with lag accumulation and
// cascade, and entry reads with division and mean correction.
// ----------------------------------------------------------------------------
module mtc_back
    import mtc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_ready,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    // per-level state
    logic [FILL_W-1:0]        fill_reg  [LEVELS];
    logic [PT_W-1:0]          wpos_reg  [LEVELS];
    logic signed [BSUM_W-1:0] bsum_reg  [LEVELS];
    logic [BFILL_W-1:0]       bfill_reg [LEVELS];

    // cell memories
    logic signed [SMP_W-1:0]  ring_mem [CELLS];
    acc_t                     acc_mem  [CELLS];

    state_t                   state_reg, state_next;
    logic [LVL_W-1:0]         k_reg, k_next;
    logic signed [SMP_W-1:0]  v_reg, v_next;
    logic signed [SMP_W-1:0]  mean_reg, mean_next;
    logic                     casc_reg, casc_next;
    logic [FILL_W-1:0]        j_reg, j_next;
    logic [FILL_W-1:0]        lim_reg, lim_next;
    logic [FILL_W-1:0]        ofill_reg, ofill_next;
    logic [PT_W-1:0]          wp_reg, wp_next;
    logic [LVL_W-1:0]         top_reg, top_next;
    logic signed [SUM_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]         count0_reg, count0_next;
    in_item_t                 cur_reg, cur_next;
    logic                     rneg_reg, rneg_next;
    logic                     mneg_reg, mneg_next;
    logic [CNT_W-1:0]         rcnt_reg, rcnt_next;
    logic                     ok_reg, ok_next;
    logic signed [SUM_W-1:0]  q_reg, q_next;
    logic signed [31:0]       m32_reg, m32_next;
    logic signed [SUM_W-1:0]  aux_reg, aux_next;
    out_item_t                out_reg, out_next;
    logic                     outv_reg, outv_next;

    // lag pipeline
    logic                     p1_valid_reg, p2_valid_reg;
    logic                     p1_fresh_reg;
    logic [CELL_W-1:0]        p1_addr_reg, p2_addr_reg;
    logic signed [SMP_W-1:0]  ring_q;
    acc_t                     acc_q;
    logic signed [PROD_W-1:0] prod_reg;
    acc_t                     acc2_reg;

    logic                     issue;
    logic [CELL_W-1:0]        ring_raddr, acc_raddr;
    logic                     ring_we;
    logic [CELL_W-1:0]        ring_waddr;
    acc_t                     acc_wdata;

    logic                     lvl_we;
    logic [FILL_W-1:0]        lvl_fill;
    logic [PT_W-1:0]          lvl_wp;
    logic signed [BSUM_W-1:0] lvl_bsum;
    logic [BFILL_W-1:0]       lvl_bfill;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic [FILL_W-1:0]        first_lag;
    logic [FILL_W-1:0]        fill_new;
    logic signed [BSUM_W-1:0] bs;
    logic [BFILL_W-1:0]       bf;
    logic [LVL_W-1:0]         rd_lvl;
    logic                     lvl_ok;
    logic                     cell_ok;
    logic [CNT_W-1:0]         rd_cnt;
    logic signed [SUM_W-1:0]  rd_sum;
    logic [WIDE_T_W-1:0]      wide_t;
    logic [TIME_W-1:0]        lag_time;

    mtc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign rd_lvl     = LVL_W'(cur_reg.level);
    assign acc_raddr  = (state_reg == ST_ADD_LAG) ? cell_addr(k_reg, j_reg[PT_W-1:0])
                                                  : cell_addr(rd_lvl, PT_W'(cur_reg.lag));
    assign ring_raddr = cell_addr(k_reg, wp_reg - j_reg[PT_W-1:0]);
    assign ring_waddr = cell_addr(k_reg, wpos_reg[k_reg]);
    assign acc_wdata.sum = sat_add(acc2_reg.sum, SUM_W'(prod_reg));
    assign acc_wdata.cnt = (acc2_reg.cnt == CNT_MAX) ? acc2_reg.cnt : acc2_reg.cnt + 1'b1;

    always_comb
    begin
        wide_t = WIDE_T_W'(cur_reg.lag) << (int'(cur_reg.level) * AVG_SH);
        if ((wide_t >> TIME_W) != '0)
            lag_time = TIME_MAX;
        else
            lag_time = wide_t[TIME_W-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        v_next      = v_reg;
        mean_next   = mean_reg;
        casc_next   = casc_reg;
        j_next      = j_reg;
        lim_next    = lim_reg;
        ofill_next  = ofill_reg;
        wp_next     = wp_reg;
        top_next    = top_reg;
        total_next  = total_reg;
        count0_next = count0_reg;
        cur_next    = cur_reg;
        rneg_next   = rneg_reg;
        mneg_next   = mneg_reg;
        rcnt_next   = rcnt_reg;
        ok_next     = ok_reg;
        q_next      = q_reg;
        m32_next    = m32_reg;
        aux_next    = aux_reg;
        out_next    = out_reg;
        outv_next   = outv_reg && !result_ready;
        cmd_ready   = 1'b0;
        issue       = 1'b0;
        ring_we     = 1'b0;
        lvl_we      = 1'b0;
        div_req     = '0;

        first_lag = (k_reg == '0) ? '0 : FILL_W'(FIRST_LAG);
        fill_new  = (fill_reg[k_reg] == FILL_W'(POINTS)) ? fill_reg[k_reg]
                                                          : fill_reg[k_reg] + 1'b1;
        bs        = bsum_reg[k_reg] + BSUM_W'(v_reg);
        bf        = bfill_reg[k_reg] + 1'b1;
        lvl_fill  = fill_new;
        lvl_wp    = wpos_reg[k_reg] + 1'b1;
        lvl_bsum  = bs;
        lvl_bfill = bf;

        lvl_ok  = (int'(cur_reg.level) < LEVELS) && (int'(cur_reg.lag) < POINTS);
        cell_ok = lvl_ok && ((cur_reg.level == '0) ||
                  ((int'(cur_reg.level) < int'(top_reg)) && (int'(cur_reg.lag) >= FIRST_LAG)));
        if (int'(cur_reg.lag) < int'(fill_reg[rd_lvl]))
        begin
            rd_cnt = acc_q.cnt;
            rd_sum = acc_q.sum;
        end
        else
        begin
            rd_cnt = '0;
            rd_sum = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cur_next = cmd.item;
                    k_next   = LVL_W'(cmd.item.level);
                    v_next   = {cmd.item.sample, 8'h00};
                    priority case (cmd.kind)
                        KIND_ADD:  state_next = ST_ADD_LVL;
                        KIND_READ: state_next = ST_RD_ADDR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_LVL:
            begin
                ring_we = 1'b1;
                lvl_we  = 1'b1;
                if (k_reg > top_reg)
                    top_next = k_reg;
                if (k_reg == '0)
                begin
                    total_next  = sat_add(total_reg, SUM_W'(v_reg));
                    count0_next = (count0_reg == CNT_MAX) ? count0_reg : count0_reg + 1'b1;
                end
                if (bf == BFILL_W'(AVERAGING))
                begin
                    lvl_bsum  = '0;
                    lvl_bfill = '0;
                    casc_next = 1'b1;
                    mean_next = SMP_W'(bs >>> AVG_SH);
                end
                else
                begin
                    casc_next = 1'b0;
                end
                wp_next    = wpos_reg[k_reg];
                j_next     = first_lag;
                lim_next   = fill_new;
                ofill_next = fill_reg[k_reg];
                state_next = (first_lag < fill_new) ? ST_ADD_LAG : ST_ADD_DRAIN;
            end
            ST_ADD_LAG:
            begin
                issue  = 1'b1;
                j_next = j_reg + 1'b1;
                if (j_next == lim_reg)
                    state_next = ST_ADD_DRAIN;
            end
            ST_ADD_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    if (casc_reg && int'(k_reg) != LEVELS - 1)
                    begin
                        k_next     = k_reg + 1'b1;
                        v_next     = mean_reg;
                        state_next = ST_ADD_LVL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if (cell_ok && rd_cnt != '0)
                begin
                    ok_next          = 1'b1;
                    rneg_next        = rd_sum[SUM_W-1];
                    rcnt_next        = rd_cnt;
                    div_req.start    = 1'b1;
                    div_req.dividend = mag64(rd_sum);
                    div_req.divisor  = rd_cnt;
                    state_next       = ST_DIV_Q;
                end
                else
                begin
                    ok_next    = 1'b0;
                    state_next = ST_RD_FIN;
                end
            end
            ST_DIV_Q:
            begin
                if (div_rsp.done)
                begin
                    q_next = rneg_reg ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
                    if (cur_reg.subtract_mean && count0_reg != '0)
                    begin
                        mneg_next        = total_reg[SUM_W-1];
                        div_req.start    = 1'b1;
                        div_req.dividend = mag64(total_reg);
                        div_req.divisor  = count0_reg;
                        state_next       = ST_DIV_M;
                    end
                    else
                    begin
                        aux_next   = '0;
                        state_next = ST_RD_FIN;
                    end
                end
            end
            ST_DIV_M:
            begin
                if (div_rsp.done)
                begin
                    if (mneg_reg)
                        m32_next = (div_rsp.quotient >= 64'h8000_0000) ? 32'sh8000_0000
                                 : -$signed(div_rsp.quotient[31:0]);
                    else
                        m32_next = (div_rsp.quotient > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                 : $signed(div_rsp.quotient[31:0]);
                    state_next = ST_MSQ;
                end
            end
            ST_MSQ:
            begin
                aux_next   = m32_reg * m32_reg;
                state_next = ST_RD_FIN;
            end
            ST_RD_FIN:
            begin
                if (!outv_reg || result_ready)
                begin
                    outv_next = 1'b1;
                    if (ok_reg)
                    begin
                        out_next.lag_time     = lag_time;
                        out_next.mean_product = sat_add(q_reg, -aux_reg);
                        out_next.pair_total   = rcnt_reg;
                        out_next.valid_res    = 1'b1;
                    end
                    else
                    begin
                        out_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            top_reg      <= '0;
            total_reg    <= '0;
            count0_reg   <= '0;
            casc_reg     <= 1'b0;
            outv_reg     <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                fill_reg[i]  <= '0;
                wpos_reg[i]  <= '0;
                bsum_reg[i]  <= '0;
                bfill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            total_reg    <= total_next;
            count0_reg   <= count0_next;
            casc_reg     <= casc_next;
            outv_reg     <= outv_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            if (lvl_we)
            begin
                fill_reg[k_reg]  <= lvl_fill;
                wpos_reg[k_reg]  <= lvl_wp;
                bsum_reg[k_reg]  <= lvl_bsum;
                bfill_reg[k_reg] <= lvl_bfill;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        v_reg     <= v_next;
        mean_reg  <= mean_next;
        j_reg     <= j_next;
        lim_reg   <= lim_next;
        ofill_reg <= ofill_next;
        wp_reg    <= wp_next;
        cur_reg   <= cur_next;
        rneg_reg  <= rneg_next;
        mneg_reg  <= mneg_next;
        rcnt_reg  <= rcnt_next;
        ok_reg    <= ok_next;
        q_reg     <= q_next;
        m32_reg   <= m32_next;
        aux_reg   <= aux_next;
        out_reg   <= out_next;
    end

    // multiply stage; start a lag entry from zero on its first accumulation
    always_ff @(posedge clk)
    begin
        p1_addr_reg  <= acc_raddr;
        p2_addr_reg  <= p1_addr_reg;
        p1_fresh_reg <= issue && (j_reg >= ofill_reg);
        prod_reg     <= v_reg * ring_q;
        acc2_reg     <= p1_fresh_reg ? '0 : acc_q;
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ring_waddr] <= v_reg;
        ring_q <= ring_mem[ring_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (p2_valid_reg)
            acc_mem[p2_addr_reg] <= acc_wdata;
        acc_q <= acc_mem[acc_raddr];
    end

    assign result_valid = outv_reg;
    assign result       = out_reg;

endmodule

[hw/rtl/multi_tau_correlator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_tau_correlator_unit
// Multi-tau autocorrelator with sample insert and per-entry read.
// ----------------------------------------------------------------------------
// An add transaction walks the filled lags of its first level and, for each
// level it cascades into, the filled lags from POINTS/AVERAGING upward, one
// lag per cycle through the accumulator memory. A read uses the
// one-bit-per-cycle divider once, or twice with mean subtraction. Adds
// produce no result; every read produces one. A two-entry input queue and
// an output register let both sides stall independently. No clearing pass
// is needed after reset.
module multi_tau_correlator_unit
    import mtc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    mtc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_ready  (cmd_ready)
    );

    mtc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_ready    (cmd_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[hw/rtl/mtc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_port_checks
// Port-level checks of the multi-tau correlator, bound to the top level.
// ----------------------------------------------------------------------------
module mtc_port_checks
    import mtc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_ready,
    input in_item_t  item,
    input logic      result_valid,
    input logic      result_ready,
    input out_item_t result
);

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("input changed while stalled");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.valid_res |->
            result.lag_time == '0 && result.mean_product == '0 && result.pair_total == '0)
        else $error("invalid result carries data");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.valid_res |-> result.pair_total != '0)
        else $error("valid result with zero count");

endmodule

bind multi_tau_correlator_unit mtc_port_checks u_mtc_port_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
